// ----- hdl/wfa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the waveform frame averager.
// Used by wfa_div, wfa_cal and waveform_frame_averager; depends on nothing.
package wfa_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 12;
    localparam int TIME_W   = 44;
    localparam int VAL_W    = 48;
    localparam int RSUM_W   = 48;
    localparam int WSUM_W   = 32;
    localparam int FCNT_W   = 32;
    localparam int WCNT_W   = 16;
    localparam int FLEN_W   = 13;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W  = POS_W + TIME_W + 3 * VAL_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_OFFSET   = 3'd5;

    // register reset values
    localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST  = 13'd4096;
    localparam logic [WCNT_W-1:0] WINDOW_FRAMES_RST = 16'd1;
    localparam logic [CFG_W-1:0]  TIME_OFFSET_RST   = 32'd0;
    localparam logic [CFG_W-1:0]  TIME_STEP_RST     = 32'd65536;
    localparam logic [CFG_W-1:0]  VOLT_GAIN_RST     = 32'd16777216;
    localparam logic [CFG_W-1:0]  VOLT_OFFSET_RST   = 32'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_CAL,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/wfa_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module wfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/wfa_div.sv -----
`timescale 1ns / 1ps
// Bit-serial average unit: min((sum*2^16 + div/2) / div, 2^32-1), one quotient
// bit per cycle. Depends on wfa_pkg.
module wfa_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [wfa_pkg::RSUM_W-1:0]      sum,
    input  logic [wfa_pkg::FCNT_W-1:0]      divisor,
    output logic                            busy,
    output logic [wfa_pkg::FCNT_W-1:0]      quot
);

    logic [64:0] numer;
    logic [32:0] rem_step;
    logic        ge;
    logic [31:0] rem_reg, lo_reg, quot_reg, div_reg;
    logic        sat_reg, busy_reg;
    logic [4:0]  cnt_reg;

    // rounding term folded into the numerator
    assign numer    = {1'b0, sum, 16'h0000} + 65'(divisor >> 1);
    assign rem_step = {rem_reg, lo_reg[31]};
    assign ge       = rem_step >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg  <= divisor;
            sat_reg  <= numer[64:32] >= {1'b0, divisor};
            rem_reg  <= numer[63:32];
            lo_reg   <= numer[31:0];
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? 32'(rem_step - {1'b0, div_reg}) : rem_step[31:0];
            lo_reg   <= {lo_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = sat_reg ? '1 : quot_reg;

endmodule

// ----- hdl/wfa_cal.sv -----
`timescale 1ns / 1ps
// Calibration: unsigned Q16.16 value times Q8.24 gain, rounded, plus offset.
// Product is registered on load; the rest is combinational. Depends on wfa_pkg.
module wfa_cal (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [31:0]                       q16,
    input  logic signed [wfa_pkg::CFG_W-1:0]  gain,
    input  logic signed [wfa_pkg::CFG_W-1:0]  offset,
    output logic signed [wfa_pkg::VAL_W-1:0]  result
);

    logic [31:0]        mag;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic [63:0]        rnd;
    logic signed [41:0] mag_r, signed_r, res;

    assign mag = gain[31] ? (~gain + 32'd1) : gain;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= {32'h0000_0000, q16} * {32'h0000_0000, mag};
            neg_reg  <= gain[31];
        end
    end

    // round half away from zero: round the magnitude, then apply sign
    assign rnd      = prod_reg + 64'h0000_0000_0080_0000;
    assign mag_r    = {2'b00, rnd[63:24]};
    assign signed_r = neg_reg ? -mag_r : mag_r;
    assign res      = signed_r + 42'(offset);
    assign result   = 48'(res);

endmodule

// ----- hdl/waveform_frame_averager.sv -----
`timescale 1ns / 1ps
// An accepted request passes the update state (ST_RMW), waits in ST_DIV until both bit-serial
// average dividers finish, then takes the multiply (ST_CAL) and the output load (ST_DONE) before
// m_tvalid. Samples are handled one at a time: s_tready is high only in ST_IDLE, so a new sample
// waits until the last one is loaded out; the done state also stalls while the output register
// holds an unaccepted result. After reset a clearing pass over all MAX_SAMPLES addresses zeroes
// both sum memories while s_tready stays low. Depends on wfa_pkg, wfa_ram, wfa_div, wfa_cal.
module waveform_frame_averager #(
    parameter int MAX_SAMPLES = wfa_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wfa_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wfa_pkg::SAMPLE_W-1:0]      s_tdata,  // sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_position, time_value, scaled_sample, running_average, window_average
    output logic [wfa_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,  // frame_end
    output logic [0:0]                        m_tuser   // window_valid
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int LW = (AW + 1 > wfa_pkg::FLEN_W) ? AW + 1 : wfa_pkg::FLEN_W;
    localparam int TPW = AW + 33;
    localparam int SW = (TPW + 1 > wfa_pkg::TIME_W + 1) ? TPW + 1 : wfa_pkg::TIME_W + 1;

    // configuration
    logic [wfa_pkg::FLEN_W-1:0] frame_length_reg;
    logic [wfa_pkg::WCNT_W-1:0] window_frames_reg;
    logic signed [31:0] time_offset_reg, time_step_reg, volt_gain_reg, volt_offset_reg;

    wfa_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_addr_reg, pos_reg, pos_item_reg;
    logic [wfa_pkg::FCNT_W-1:0] frame_cnt_reg;
    logic [wfa_pkg::WCNT_W-1:0] win_cnt_reg;
    logic [wfa_pkg::SAMPLE_W-1:0] sample_reg;
    logic wvalid_reg, fend_reg;
    logic signed [TPW-1:0] tprod_reg;

    logic m_tvalid_reg;
    logic [wfa_pkg::TDATA_W-1:0] m_tdata_reg;
    logic m_tlast_reg, m_tuser_reg;

    // control strobes
    logic in_fire, ram_we, div_start, cal_load, out_load;

    // memory side
    logic [AW-1:0] waddr;
    logic [wfa_pkg::RSUM_W-1:0] rs_rdata, rs_wdata, rs_new;
    logic [wfa_pkg::WSUM_W-1:0] ws_rdata, ws_wdata, ws_new;
    logic [wfa_pkg::RSUM_W:0] rs_sum;
    logic [wfa_pkg::WSUM_W:0] ws_sum;

    logic [LW-1:0] fl_ext, len_eff;
    logic [wfa_pkg::WCNT_W-1:0] wf_eff;
    logic active, wvalid, fend;
    logic [wfa_pkg::WCNT_W:0] wcnt_inc;
    logic [wfa_pkg::FCNT_W-1:0] div_run;

    logic run_busy, win_busy;
    logic [31:0] run_q, win_q;
    logic signed [wfa_pkg::VAL_W-1:0] cal_s, cal_r, cal_w, win_avg;

    logic signed [SW-1:0] tsum;
    logic [SW-44:0] tsum_hi;
    logic [wfa_pkg::TIME_W-1:0] tval;

    // ---------------- configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg  <= wfa_pkg::FRAME_LENGTH_RST;
            window_frames_reg <= wfa_pkg::WINDOW_FRAMES_RST;
            time_offset_reg   <= wfa_pkg::TIME_OFFSET_RST;
            time_step_reg     <= wfa_pkg::TIME_STEP_RST;
            volt_gain_reg     <= wfa_pkg::VOLT_GAIN_RST;
            volt_offset_reg   <= wfa_pkg::VOLT_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wfa_pkg::CFG_FRAME_LENGTH:  frame_length_reg  <= cfg_wdata[wfa_pkg::FLEN_W-1:0];
                wfa_pkg::CFG_WINDOW_FRAMES: window_frames_reg <= cfg_wdata[wfa_pkg::WCNT_W-1:0];
                wfa_pkg::CFG_TIME_OFFSET:   time_offset_reg   <= cfg_wdata;
                wfa_pkg::CFG_TIME_STEP:     time_step_reg     <= cfg_wdata;
                wfa_pkg::CFG_VOLT_GAIN:     volt_gain_reg     <= cfg_wdata;
                wfa_pkg::CFG_VOLT_OFFSET:   volt_offset_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- effective lengths and per-sample decisions
    always_comb begin
        fl_ext = LW'(frame_length_reg);
        if (fl_ext == '0) begin
            len_eff = LW'(1);
        end else if (fl_ext > LW'(MAX_SAMPLES)) begin
            len_eff = LW'(MAX_SAMPLES);
        end else begin
            len_eff = fl_ext;
        end
        wf_eff = (window_frames_reg == '0) ? wfa_pkg::WCNT_W'(1) : window_frames_reg;
    end

    assign active   = frame_cnt_reg != '1;
    assign wcnt_inc = {1'b0, win_cnt_reg} + 17'd1;
    assign wvalid   = active && (wcnt_inc >= {1'b0, wf_eff});
    assign fend     = (LW'(pos_item_reg) + LW'(1)) >= len_eff;
    assign div_run  = active ? frame_cnt_reg + 32'd1 : frame_cnt_reg;

    assign rs_sum = {1'b0, rs_rdata} + 49'(sample_reg);
    assign ws_sum = {1'b0, ws_rdata} + 33'(sample_reg);
    assign rs_new = rs_sum[wfa_pkg::RSUM_W] ? '1 : rs_sum[wfa_pkg::RSUM_W-1:0];
    assign ws_new = ws_sum[wfa_pkg::WSUM_W] ? '1 : ws_sum[wfa_pkg::WSUM_W-1:0];

    assign rs_wdata = (state_reg == wfa_pkg::ST_CLEAR) ? '0 : rs_new;
    assign ws_wdata = (state_reg == wfa_pkg::ST_CLEAR || wvalid) ? '0 : ws_new;
    assign waddr    = (state_reg == wfa_pkg::ST_CLEAR) ? clr_addr_reg : pos_item_reg;

    // ---------------- memories
    wfa_ram #(.WIDTH(wfa_pkg::RSUM_W), .DEPTH(MAX_SAMPLES)) u_run_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (rs_wdata),
        .raddr (pos_reg),
        .rdata (rs_rdata)
    );

    wfa_ram #(.WIDTH(wfa_pkg::WSUM_W), .DEPTH(MAX_SAMPLES)) u_win_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (ws_wdata),
        .raddr (pos_reg),
        .rdata (ws_rdata)
    );

    // ---------------- dividers
    wfa_div u_run_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (active ? rs_new : rs_rdata),
        .divisor (div_run),
        .busy    (run_busy),
        .quot    (run_q)
    );

    wfa_div u_win_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (48'(ws_new)),
        .divisor (32'(wf_eff)),
        .busy    (win_busy),
        .quot    (win_q)
    );

    // ---------------- calibration
    wfa_cal u_cal_s (
        .aclk (aclk), .load (cal_load), .q16 ({sample_reg, 16'h0000}),
        .gain (volt_gain_reg), .offset (volt_offset_reg), .result (cal_s)
    );

    wfa_cal u_cal_r (
        .aclk (aclk), .load (cal_load), .q16 (run_q),
        .gain (volt_gain_reg), .offset (volt_offset_reg), .result (cal_r)
    );

    wfa_cal u_cal_w (
        .aclk (aclk), .load (cal_load), .q16 (win_q),
        .gain (volt_gain_reg), .offset (volt_offset_reg), .result (cal_w)
    );

    assign win_avg = wvalid_reg ? cal_w : '0;

    // time axis, saturated to 44 bits
    always_comb begin
        tsum    = SW'(tprod_reg) + SW'(time_offset_reg);
        tsum_hi = tsum[SW-1:wfa_pkg::TIME_W-1];
        if ((&tsum_hi) || !(|tsum_hi)) begin
            tval = tsum[wfa_pkg::TIME_W-1:0];
        end else if (tsum[SW-1]) begin
            tval = {1'b1, {(wfa_pkg::TIME_W-1){1'b0}}};
        end else begin
            tval = {1'b0, {(wfa_pkg::TIME_W-1){1'b1}}};
        end
    end

    // ---------------- sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wfa_pkg::ST_CLEAR: begin
                if (clr_addr_reg == AW'(MAX_SAMPLES - 1)) begin
                    state_next = wfa_pkg::ST_IDLE;
                end
            end
            wfa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = wfa_pkg::ST_RMW;
                end
            end
            wfa_pkg::ST_RMW: state_next = wfa_pkg::ST_DIV;
            wfa_pkg::ST_DIV: begin
                if (!run_busy && !win_busy) begin
                    state_next = wfa_pkg::ST_CAL;
                end
            end
            wfa_pkg::ST_CAL: state_next = wfa_pkg::ST_DONE;
            wfa_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = wfa_pkg::ST_IDLE;
                end
            end
            default: state_next = wfa_pkg::ST_CLEAR;
        endcase
    end

    // ---------------- sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        cal_load  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            wfa_pkg::ST_CLEAR: ram_we = 1'b1;
            wfa_pkg::ST_IDLE:  s_tready = 1'b1;
            wfa_pkg::ST_RMW: begin
                ram_we    = active;
                div_start = 1'b1;
            end
            wfa_pkg::ST_CAL:  cal_load = 1'b1;
            wfa_pkg::ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_fire = s_tvalid && s_tready;

    // ---------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wfa_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            frame_cnt_reg <= '0;
            win_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wfa_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == wfa_pkg::ST_RMW) begin
                if (fend) begin
                    pos_reg <= '0;
                    if (active) begin
                        frame_cnt_reg <= frame_cnt_reg + 32'd1;
                        win_cnt_reg   <= wvalid ? '0 : wcnt_inc[wfa_pkg::WCNT_W-1:0];
                    end
                end else begin
                    pos_reg <= pos_item_reg + AW'(1);
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg   <= s_tdata;
            pos_item_reg <= pos_reg;
        end
        if (state_reg == wfa_pkg::ST_RMW) begin
            wvalid_reg <= wvalid;
            fend_reg   <= fend;
            tprod_reg  <= TPW'($signed({1'b0, pos_item_reg})) * TPW'(time_step_reg);
        end
        if (out_load) begin
            m_tdata_reg <= {win_avg, cal_r, cal_s, tval,
                            wfa_pkg::POS_W'({{(32 - AW){1'b0}}, pos_item_reg})};
            m_tlast_reg <= fend_reg;
            m_tuser_reg <= wvalid_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- assertions
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wfa_pkg::ST_CLEAR |-> !s_tready)
        else $error("request accepted during clearing pass");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == wfa_pkg::ST_CLEAR || state_reg == wfa_pkg::ST_RMW))
        else $error("sum memory written outside clear or update");

    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wfa_pkg::ST_RMW |=> (run_busy && win_busy))
        else $error("dividers not started after update");

    a_win_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg[wfa_pkg::TDATA_W-1 -: wfa_pkg::VAL_W] == '0))
        else $error("window average nonzero without window_valid");

endmodule

// ----- bench/waveform_frame_averager_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for waveform_frame_averager: drives samples and register
// writes, predicts every result in-bench and checks it. Depends on wfa_pkg and the RTL.
module waveform_frame_averager_test;

    localparam longint MAX48 = 64'sd140737488355327;
    localparam longint MIN48 = -64'sd140737488355328;
    localparam longint MAX44 = 64'sd8796093022207;
    localparam longint MIN44 = -64'sd8796093022208;
    localparam longint unsigned FRAME_SAT = 64'hFFFF_FFFF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [wfa_pkg::POS_W-1:0]  pos;
        logic [wfa_pkg::TIME_W-1:0] tval;
        logic [wfa_pkg::VAL_W-1:0]  scaled;
        logic [wfa_pkg::VAL_W-1:0]  ravg;
        logic [wfa_pkg::VAL_W-1:0]  wavg;
        logic                       wvalid;
        logic                       fend;
    } avg_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [wfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wfa_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [wfa_pkg::SAMPLE_W-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [wfa_pkg::TDATA_W-1:0]   m_tdata;
    logic                          m_tlast;
    logic [0:0]                    m_tuser;

    waveform_frame_averager i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor copy of registers and state
    longint unsigned reg_len, reg_wf;
    longint          reg_toff, reg_tstep, reg_gain, reg_voff;
    longint unsigned run_sum [wfa_pkg::MAX_SAMPLES_DEF];
    longint unsigned win_sum [wfa_pkg::MAX_SAMPLES_DEF];
    longint unsigned pos_cnt, frame_cnt, win_cnt;

    avg_result_t expected_results[$];
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_windows = 0;
    int idle_cycles = 0;
    bit full_speed = 1'b0;
    int rdy_hold = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // unsigned Q16.16 quotient, fraction rounded half up, saturated to 32 bits
    function automatic longint unsigned avg_q16(longint unsigned sum, longint unsigned dv);
        longint unsigned q, r, frac, v;
        q = sum / dv;
        r = sum % dv;
        frac = ((r << 16) + dv / 2) / dv;
        if (q > 64'hFFFF) return FRAME_SAT;
        v = (q << 16) + frac;
        return v > FRAME_SAT ? FRAME_SAT : v;
    endfunction

    function automatic longint calibrate(longint unsigned q16);
        longint unsigned mag, p, r;
        longint s;
        mag = reg_gain < 0 ? longint'(-reg_gain) : longint'(reg_gain);
        if (q16 > FRAME_SAT) q16 = FRAME_SAT;
        p = q16 * mag;
        r = (p + (64'd1 << 23)) >> 24;
        s = reg_gain < 0 ? -longint'(r) : longint'(r);
        return clamp(s + reg_voff, MIN48, MAX48);
    endfunction

    task automatic predict_sample(logic [wfa_pkg::SAMPLE_W-1:0] smp);
        longint unsigned len, wf, idx, dv, rs, ws;
        bit active;
        avg_result_t e;
        len = reg_len == 0 ? 1 : reg_len;
        if (len > wfa_pkg::MAX_SAMPLES_DEF) len = wfa_pkg::MAX_SAMPLES_DEF;
        wf = reg_wf == 0 ? 1 : reg_wf;
        idx = pos_cnt % wfa_pkg::MAX_SAMPLES_DEF;
        active = frame_cnt < FRAME_SAT;
        e = '0;
        e.pos = pos_cnt[wfa_pkg::POS_W-1:0];
        e.tval = wfa_pkg::TIME_W'(clamp(reg_toff + longint'(pos_cnt) * reg_tstep,
                                        MIN44, MAX44));
        if (active) begin
            rs = run_sum[idx] + smp;
            ws = win_sum[idx] + smp;
            run_sum[idx] = rs > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : rs;
            win_sum[idx] = ws > FRAME_SAT ? FRAME_SAT : ws;
        end
        dv = active ? frame_cnt + 1 : frame_cnt;
        e.wvalid = active && (win_cnt + 1 >= wf);
        if (e.wvalid) begin
            e.wavg = wfa_pkg::VAL_W'(calibrate(avg_q16(win_sum[idx], wf)));
            win_sum[idx] = 0;
        end
        e.fend = pos_cnt + 1 >= len;
        e.scaled = wfa_pkg::VAL_W'(calibrate(longint'(smp) << 16));
        e.ravg = wfa_pkg::VAL_W'(calibrate(avg_q16(run_sum[idx], dv)));
        expected_results.push_back(e);
        if (e.fend) begin
            pos_cnt = 0;
            if (active) begin
                frame_cnt++;
                win_cnt = e.wvalid ? 0 : (win_cnt + 1) & 64'hFFFF;
            end
        end else begin
            pos_cnt = pos_cnt + 1;
        end
    endtask

    // input monitor: every accepted request feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_sample(s_tdata);
            n_requests++;
        end
    end

    // result checker
    always @(posedge aclk) begin
        avg_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("unexpected result, tdata %h", m_tdata);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.wvalid) n_windows++;
                if (m_tdata[11:0] !== e.pos) begin
                    $error("sample_position exp %0d got %0d", e.pos, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[55:12] !== e.tval) begin
                    $error("time_value exp %h got %h", e.tval, m_tdata[55:12]);
                    errors++;
                end
                if (m_tdata[103:56] !== e.scaled) begin
                    $error("scaled_sample exp %h got %h", e.scaled, m_tdata[103:56]);
                    errors++;
                end
                if (m_tdata[151:104] !== e.ravg) begin
                    $error("running_average exp %h got %h", e.ravg, m_tdata[151:104]);
                    errors++;
                end
                if (m_tdata[199:152] !== e.wavg) begin
                    $error("window_average exp %h got %h", e.wavg, m_tdata[199:152]);
                    errors++;
                end
                if (m_tuser[0] !== e.wvalid) begin
                    $error("window_valid exp %b got %b", e.wvalid, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== e.fend) begin
                    $error("frame_end exp %b got %b", e.fend, m_tlast);
                    errors++;
                end
            end
        end
    end

    // result-side backpressure
    always @(posedge aclk) begin
        if (full_speed) begin
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            m_tready <= $urandom_range(0, 2) != 0;
            rdy_hold <= gap_len();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("waveform_frame_averager_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(logic [wfa_pkg::SAMPLE_W-1:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        do @(posedge aclk); while (!s_tready);
        gap = full_speed ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [wfa_pkg::CFG_IDX_W-1:0] idx,
                             logic [wfa_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            wfa_pkg::CFG_FRAME_LENGTH:  reg_len = val[wfa_pkg::FLEN_W-1:0];
            wfa_pkg::CFG_WINDOW_FRAMES: reg_wf = val[wfa_pkg::WCNT_W-1:0];
            wfa_pkg::CFG_TIME_OFFSET:   reg_toff = longint'(signed'(val));
            wfa_pkg::CFG_TIME_STEP:     reg_tstep = longint'(signed'(val));
            wfa_pkg::CFG_VOLT_GAIN:     reg_gain = longint'(signed'(val));
            wfa_pkg::CFG_VOLT_OFFSET:   reg_voff = longint'(signed'(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic do_reset();
        reg_len = wfa_pkg::FRAME_LENGTH_RST;
        reg_wf = wfa_pkg::WINDOW_FRAMES_RST;
        reg_toff = 0;
        reg_tstep = 65536;
        reg_gain = 16777216;
        reg_voff = 0;
        foreach (run_sum[i]) begin
            run_sum[i] = 0;
            win_sum[i] = 0;
        end
        pos_cnt = 0;
        frame_cnt = 0;
        win_cnt = 0;
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_extremes();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();
        write_reg(wfa_pkg::CFG_FRAME_LENGTH, 32'd0);   // zero length acts as one
        write_reg(wfa_pkg::CFG_WINDOW_FRAMES, 32'd0);  // zero window acts as one
        send_sample(16'hFFFF);
        send_sample(16'hA5A5);
        drain();
        write_reg(wfa_pkg::CFG_VOLT_GAIN, 32'h8000_0000);
        write_reg(wfa_pkg::CFG_VOLT_OFFSET, 32'h7FFF_FFFF);
        write_reg(wfa_pkg::CFG_TIME_OFFSET, 32'h8000_0000);
        write_reg(wfa_pkg::CFG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(wfa_pkg::CFG_FRAME_LENGTH, 32'd8191); // clipped to the memory depth
        send_sample(16'hFFFF);
        send_sample(16'h5A5A);
        send_sample(16'h0001);
        drain();
        write_reg(wfa_pkg::CFG_VOLT_GAIN, 32'h7FFF_FFFF);
        write_reg(wfa_pkg::CFG_VOLT_OFFSET, 32'h8000_0000);
        write_reg(wfa_pkg::CFG_TIME_OFFSET, 32'h7FFF_FFFF);
        write_reg(wfa_pkg::CFG_TIME_STEP, 32'h8000_0000);
        write_reg(wfa_pkg::CFG_WINDOW_FRAMES, 32'd65535);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        drain();
    endtask

    // shrinking the frame below the current position ends the frame at once
    task automatic test_frame_shrink();
        write_reg(wfa_pkg::CFG_FRAME_LENGTH, 32'd8);
        write_reg(wfa_pkg::CFG_WINDOW_FRAMES, 32'd3);
        write_reg(wfa_pkg::CFG_VOLT_GAIN, 32'd16777216);
        write_reg(wfa_pkg::CFG_VOLT_OFFSET, 32'd0);
        repeat (5) send_sample($urandom_range(0, 16'hFFFF));
        drain();
        write_reg(wfa_pkg::CFG_FRAME_LENGTH, 32'd3);
        repeat (4) send_sample($urandom_range(0, 16'hFFFF));
        drain();
    endtask

    // lowering the window below the frames already summed closes it next frame
    task automatic test_window_shrink();
        write_reg(wfa_pkg::CFG_FRAME_LENGTH, 32'd2);
        write_reg(wfa_pkg::CFG_WINDOW_FRAMES, 32'd5);
        repeat (6) send_sample($urandom_range(0, 16'hFFFF));
        drain();
        write_reg(wfa_pkg::CFG_WINDOW_FRAMES, 32'd2);
        repeat (2) send_sample($urandom_range(0, 16'hFFFF));
        drain();
    endtask

    function automatic logic [wfa_pkg::CFG_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random();
        int r, n;
        for (int ph = 0; ph < 12; ph++) begin
            r = $urandom_range(0, 9);
            write_reg(wfa_pkg::CFG_FRAME_LENGTH, r == 0 ? 32'd0 : r == 1 ? 32'd40 :
                      r == 2 && ph == 5 ? 32'd8191 : $urandom_range(1, 12));
            r = $urandom_range(0, 9);
            write_reg(wfa_pkg::CFG_WINDOW_FRAMES, r == 0 ? 32'd0 : r == 1 ? 32'd65535 :
                      $urandom_range(1, 4));
            write_reg(wfa_pkg::CFG_TIME_OFFSET, rand_word());
            write_reg(wfa_pkg::CFG_TIME_STEP, rand_word());
            write_reg(wfa_pkg::CFG_VOLT_GAIN, $urandom_range(0, 2) == 0 ? rand_word() :
                      $urandom_range(1 << 23, 1 << 25));
            write_reg(wfa_pkg::CFG_VOLT_OFFSET, rand_word());
            full_speed = (ph % 4 == 3);
            n = $urandom_range(40, 75);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                send_sample(r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : $urandom_range(0, 16'hFFFF));
            end
            drain();
        end
        full_speed = 1'b0;
    endtask

    initial begin
        do_reset();
        test_extremes();
        test_frame_shrink();
        test_window_shrink();
        test_random();
        drain();
        $display("Covered %0d samples, %0d results, %0d window completions,",
                 n_requests, n_results, n_windows);
        $display("over extreme and random frame, window and calibration settings.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("waveform_frame_averager_test: done, clean");
        end else begin
            $display("waveform_frame_averager_test: done, errors");
        end
        $finish;
    end

endmodule
